// File: rtl/hbm_pkg.sv
// shared types, codes and constants of the histogram axis bin mapper
`default_nettype none
package hbm_pkg;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int DIV_STEPS = 16;

    localparam logic [1:0] KIND_DIRECT   = 2'd0;
    localparam logic [1:0] KIND_CALC     = 2'd1;
    localparam logic [1:0] KIND_BOUNDARY = 2'd2;
    localparam logic [1:0] KIND_LOOKUP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    localparam logic [2:0] REG_MAP_KIND    = 3'd0;
    localparam logic [2:0] REG_AXIS_LENGTH = 3'd1;
    localparam logic [2:0] REG_RANGE_CHECK = 3'd2;
    localparam logic [2:0] REG_TABLE_LEN   = 3'd3;
    localparam logic [2:0] REG_SHIFT_THR   = 3'd4;
    localparam logic [2:0] REG_SHIFT_OFF   = 3'd5;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// File: rtl/hbm_ram.sv
// generic single-port ram with registered read
`default_nettype none
module hbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/hbm_div.sv
// iterative signed divider, two quotient bits per cycle, truncating
`default_nettype none
module hbm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hbm_pkg::t_div_req i_req,
    output hbm_pkg::t_div_rsp      o_rsp
);
    localparam int CW = $clog2(hbm_pkg::DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [32:0]   r_rem;
    logic [31:0]   r_quo;
    logic [31:0]   r_dvs;
    logic [32:0]   n_rem;
    logic [31:0]   n_quo;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[31:0], n_quo[31]};
            n_quo = {n_quo[30:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem  = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend[31] ? -i_req.dividend : i_req.dividend;
                r_dvs  <= i_req.divisor[31] ? -i_req.divisor : i_req.divisor;
                r_neg  <= i_req.dividend[31] ^ i_req.divisor[31];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(hbm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -r_quo : r_quo;
endmodule
`default_nettype wire

// File: rtl/histogram_axis_bin_mapper_unit.sv
// histogram axis bin mapper: sequencer around the table ram and divider
//
//  channel  | direction | handshake              | payload
//  input    | in        | i_in_valid / o_in_stall | mode, value, entry_index, entry_word
//  output   | out       | o_out_valid / i_out_stall | bin_index, status, totals
//  config   | in        | i_cfg_we               | index, data
//
// one beat at a time: write and direct go straight to S_DONE, lookup takes its word in
// S_L1, calc runs S_C1 to S_C5 and uses the divider only with a nonzero divisor, boundary
// passes S_BS and S_BM on the ram port for each bisection step
// reset clears configuration, counters and control; the table is not cleared
// a result waiting under stall holds the sequencer in its final state
`default_nettype none
module histogram_axis_bin_mapper_unit #(
    parameter int TABLE_DEPTH = hbm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_in_mode,
    input  wire logic [31:0] i_in_value,
    input  wire logic [11:0] i_in_entry_index,
    input  wire logic [31:0] i_in_entry_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_out_bin_index,
    output logic [1:0]       o_out_status,
    output logic [31:0]      o_out_below_total,
    output logic [31:0]      o_out_above_total,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DONE, S_C1, S_C2, S_C3, S_C4, S_DIV, S_C5,
        S_L1, S_B0, S_B1, S_BS, S_BM, S_BE, S_BF
    } t_state;

    t_state      r_state;
    logic [1:0]  r_kind;
    logic [30:0] r_axis;
    logic        r_chk;
    logic [12:0] r_tlen;
    logic [31:0] r_thr;
    logic [31:0] r_off;
    logic [31:0] r_below;
    logic [31:0] r_above;

    logic [31:0]   r_v;
    logic [31:0]   r_t;
    logic [31:0]   r_dv;
    logic [31:0]   r_w3;
    logic [31:0]   r_bin;
    logic [1:0]    r_status;
    logic [AW-1:0] r_left;
    logic [AW-1:0] r_right;
    logic [AW-1:0] r_mid;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    logic          accept;
    logic [31:0]   used;
    logic [AW-1:0] nm1;
    logic [31:0]   bval;
    logic [AW:0]   msum;
    logic [AW-1:0] mid;
    logic [31:0]   ct;
    logic [31:0]   n_below;
    logic [31:0]   n_above;

    hbm_pkg::t_div_req div_req;
    hbm_pkg::t_div_rsp div_rsp;

    function automatic logic [1:0] range_st(input logic [31:0] v, input logic [30:0] len);
        if (v[31]) begin
            return hbm_pkg::ST_BELOW;
        end else if (v[30:0] >= len) begin
            return hbm_pkg::ST_ABOVE;
        end
        return hbm_pkg::ST_OK;
    endfunction

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        used = ({19'd0, r_tlen} > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : {19'd0, r_tlen};
        nm1  = (used == 32'd0) ? '0 : AW'(used - 32'd1);
        bval = i_in_value;
        if (!r_thr[31] && (r_thr != 32'd0) && ($signed(i_in_value) > $signed(r_thr))) begin
            bval = i_in_value - r_off;
        end
        msum = {1'b0, r_left} + {1'b0, r_right};
        mid  = msum[AW:1];
        ct   = r_t + r_w3;
    end

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_mode) begin
                    ram_we   = ({20'd0, i_in_entry_index} < 32'(TABLE_DEPTH));
                    ram_addr = AW'(i_in_entry_index);
                end else if (r_kind == hbm_pkg::KIND_LOOKUP) begin
                    ram_addr = i_in_value[AW-1:0];
                end
            end
            S_C1:    ram_addr = AW'(1);
            S_C2:    ram_addr = AW'(2);
            S_C3:    ram_addr = AW'(3);
            S_B0:    ram_addr = r_right;
            S_BS:    ram_addr = ((r_right - r_left) == AW'(1)) ? r_right : mid;
            default: ram_addr = '0;
        endcase
    end

    hbm_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_entry_word),
        .o_rdata (ram_rdata)
    );

    assign div_req.start    = (r_state == S_C4) && (r_dv != 32'd0);
    assign div_req.dividend = r_t;
    assign div_req.divisor  = r_dv;

    hbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_below = r_below;
        n_above = r_above;
        if (r_status == hbm_pkg::ST_BELOW && r_below != 32'hFFFF_FFFF) begin
            n_below = r_below + 32'd1;
        end
        if (r_status == hbm_pkg::ST_ABOVE && r_above != 32'hFFFF_FFFF) begin
            n_above = r_above + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= hbm_pkg::KIND_DIRECT;
            r_axis      <= '0;
            r_chk       <= 1'b0;
            r_tlen      <= '0;
            r_thr       <= '0;
            r_off       <= '0;
            r_below     <= '0;
            r_above     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hbm_pkg::REG_MAP_KIND:    r_kind <= i_cfg_data[1:0];
                    hbm_pkg::REG_AXIS_LENGTH: r_axis <= i_cfg_data[30:0];
                    hbm_pkg::REG_RANGE_CHECK: r_chk  <= i_cfg_data[0];
                    hbm_pkg::REG_TABLE_LEN:   r_tlen <= i_cfg_data[12:0];
                    hbm_pkg::REG_SHIFT_THR:   r_thr  <= i_cfg_data;
                    hbm_pkg::REG_SHIFT_OFF:   r_off  <= i_cfg_data;
                    default: ;
                endcase
            end
            // in S_DONE the output register is handled by the state itself
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_mode) begin
                            r_bin    <= '0;
                            r_status <= hbm_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end else begin
                            case (r_kind)
                                hbm_pkg::KIND_DIRECT: begin
                                    r_bin    <= i_in_value;
                                    r_status <= r_chk ? range_st(i_in_value, r_axis)
                                                      : hbm_pkg::ST_OK;
                                    r_state  <= S_DONE;
                                end
                                hbm_pkg::KIND_CALC: begin
                                    r_v      <= i_in_value;
                                    r_status <= hbm_pkg::ST_OK;
                                    r_state  <= S_C1;
                                end
                                hbm_pkg::KIND_BOUNDARY: begin
                                    r_v      <= bval;
                                    r_left   <= '0;
                                    r_right  <= nm1;
                                    r_status <= hbm_pkg::ST_OK;
                                    r_state  <= r_chk ? S_B0 : S_BS;
                                end
                                default: begin
                                    if (i_in_value[31]) begin
                                        r_status <= hbm_pkg::ST_BELOW;
                                        r_state  <= S_DONE;
                                    end else if ({1'b0, i_in_value[30:0]} >= used) begin
                                        r_status <= hbm_pkg::ST_ABOVE;
                                        r_state  <= S_DONE;
                                    end else begin
                                        r_status <= hbm_pkg::ST_OK;
                                        r_state  <= S_L1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_C1: begin
                    r_t     <= (ram_rdata != 32'd0) ? r_v * ram_rdata : r_v;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_t     <= r_t + ram_rdata;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_dv    <= ram_rdata;
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_w3    <= ram_rdata;
                    r_state <= (r_dv != 32'd0) ? S_DIV : S_C5;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_t     <= div_rsp.quotient;
                        r_state <= S_C5;
                    end
                end
                S_C5: begin
                    r_bin <= ct;
                    if (r_chk) r_status <= range_st(ct, r_axis);
                    r_state <= S_DONE;
                end
                S_L1: begin
                    r_bin <= ram_rdata;
                    if (r_chk) r_status <= range_st(ram_rdata, r_axis);
                    r_state <= S_DONE;
                end
                S_B0: begin
                    if (r_v < ram_rdata) begin
                        r_status <= hbm_pkg::ST_BELOW;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_B1;
                    end
                end
                S_B1: begin
                    if (r_v >= ram_rdata) begin
                        r_status <= hbm_pkg::ST_ABOVE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_BS;
                    end
                end
                S_BS: begin
                    if (r_right == r_left) begin
                        r_bin   <= 32'(r_left);
                        r_state <= S_BF;
                    end else if ((r_right - r_left) == AW'(1)) begin
                        r_state <= S_BE;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_BM;
                    end
                end
                S_BM: begin
                    if (r_v == ram_rdata) begin
                        r_bin   <= 32'(r_mid);
                        r_state <= S_BF;
                    end else begin
                        if (r_v > ram_rdata) r_left <= r_mid;
                        else r_right <= r_mid;
                        r_state <= S_BS;
                    end
                end
                S_BE: begin
                    r_bin   <= (r_v >= ram_rdata) ? 32'(r_right) : 32'(r_left);
                    r_state <= S_BF;
                end
                S_BF: begin
                    if (r_chk && (r_bin >= {1'b0, r_axis})) r_status <= hbm_pkg::ST_ABOVE;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid       <= 1'b1;
                        o_out_bin_index   <= (r_status == hbm_pkg::ST_OK) ? r_bin : 32'd0;
                        o_out_status      <= r_status;
                        o_out_below_total <= n_below;
                        o_out_above_total <= n_above;
                        r_below           <= n_below;
                        r_above           <= n_above;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_below_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_below >= $past(r_below)) else $error("below counter went down");
    a_above_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_above >= $past(r_above)) else $error("above counter went down");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status != hbm_pkg::ST_OK) |-> (o_out_bin_index == 32'd0))
        else $error("rejected beat carries a bin");
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV)) else $error("divider finished outside calc");
endmodule
`default_nettype wire
